// ----- src/tplw_pkg.sv -----
package tplw_pkg;

   // command codes of an input beat
   localparam logic CMD_REQUEST  = 1'b0;
   localparam logic CMD_RESPONSE = 1'b1;

   // result action codes
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_DONE  = 2'd2;
   localparam logic [1:0] ACT_FAULT = 2'd3;

   // control register indexes
   localparam logic CSR_PAGING_ENABLE = 1'b0;
   localparam logic CSR_PAGE_DIR_BASE = 1'b1;

   // walk phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_DIR  = 4'b0010,
      PH_TBL  = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   // input beat payload
   typedef struct packed {
      logic        command;
      logic [31:0] virt_addr;
      logic [2:0]  size_bytes;
      logic        is_store;
      logic [31:0] store_data;
      logic [31:0] mem_data;
   } req_type;

   // result beat payload
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] phys_addr;
      logic [2:0]  req_bytes;
      logic [31:0] out_data;
   } result_type;

   // walk state carried between beats
   typedef struct packed {
      phase_type   phase;
      logic [31:0] saved_vaddr;
      logic [2:0]  saved_len;
      logic [1:0]  byte_index;
      logic        split_mode;
      logic        store_flag;
      logic [31:0] data_buffer;
   } walk_state_type;

   localparam walk_state_type WALK_RESET = '{
      phase:       PH_IDLE,
      saved_vaddr: 32'd0,
      saved_len:   3'd0,
      byte_index:  2'd0,
      split_mode:  1'b0,
      store_flag:  1'b0,
      data_buffer: 32'd0
   };

   // mask of the low n bytes of a word
   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      logic [31:0] m;
      begin
         case (n)
            3'd1: m = 32'h0000_00FF;
            3'd2: m = 32'h0000_FFFF;
            3'd3: m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
         endcase
         return m;
      end
   endfunction

endpackage

// ----- src/tplw_ifs.sv -----
// access request and memory response channel
interface tplw_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] virt_addr;
   logic [2:0]  size_bytes;
   logic        is_store;
   logic [31:0] store_data;
   logic [31:0] mem_data;

   modport source (output valid, command, virt_addr, size_bytes, is_store, store_data,
                   mem_data, input ready);
   modport sink (input valid, command, virt_addr, size_bytes, is_store, store_data,
                 mem_data, output ready);
endinterface

// result channel
interface tplw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] phys_addr;
   logic [2:0]  req_bytes;
   logic [31:0] out_data;

   modport source (output valid, action, phys_addr, req_bytes, out_data, input ready);
   modport sink (input valid, action, phys_addr, req_bytes, out_data, output ready);
endinterface

// control register write channel
interface tplw_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/two_level_page_walk_access.sv -----
// a result is registered and is on the rsp channel in the cycle after the beat that causes it
// throughput: one req beat per cycle; req ready drops only while a held result
//   is not taken by the rsp side
// each memory request costs one req response beat; an unsplit paged walk is four results
// reset: synchronous, clears walk phase to idle, registers to zero and the result valid flag
module two_level_page_walk_access import tplw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tplw_req_if.sink   req_chan,
   tplw_rsp_if.source rsp_chan,
   tplw_csr_if.sink   csr_chan
);

   logic           paging_enable_ff;
   logic [31:0]    page_dir_base_ff;
   walk_state_type state_ff;
   walk_state_type state_in;
   req_type        req;
   result_type     res;
   logic           res_valid;
   logic           space;
   logic           accept;
   logic           load;

   // control registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_enable_ff <= 1'b0;
         page_dir_base_ff <= 32'd0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PAGING_ENABLE: paging_enable_ff <= csr_chan.data[0];
            CSR_PAGE_DIR_BASE: page_dir_base_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // input beat
   assign req = '{
      command:    req_chan.command,
      virt_addr:  req_chan.virt_addr,
      size_bytes: req_chan.size_bytes,
      is_store:   req_chan.is_store,
      store_data: req_chan.store_data,
      mem_data:   req_chan.mem_data
   };

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;
   assign load           = accept && res_valid;

   tplw_step u_step (
      .req           (req),
      .paging_enable (paging_enable_ff),
      .page_dir_base (page_dir_base_ff),
      .state_ff      (state_ff),
      .state_in      (state_in),
      .res           (res),
      .res_valid     (res_valid)
   );

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   tplw_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .res      (res),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

   // a new result only follows an accepted beat
   a_result_from_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(accept))
      else $error("result appeared without an accepted beat");

   // a response while idle gives no result
   a_idle_response_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.command == CMD_RESPONSE && state_ff.phase == PH_IDLE)
      |=> !rsp_chan.valid)
      else $error("response while idle produced a result");

   // fault and done end the walk
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load && (res.action == ACT_FAULT || res.action == ACT_DONE))
      |=> state_ff.phase == PH_IDLE)
      else $error("walk did not return to idle after fault or done");

endmodule

// ----- src/tplw_step.sv -----
module tplw_step import tplw_pkg::*; (
   input  req_type        req,
   input  logic           paging_enable,
   input  logic [31:0]    page_dir_base,
   input  walk_state_type state_ff,
   output walk_state_type state_in,
   output result_type     res,
   output logic           res_valid
);

   logic [2:0]  len_clamp;
   logic [31:0] req_end;
   logic [31:0] cur_va;
   logic [2:0]  cur_len;
   logic [4:0]  byte_shift;
   logic [31:0] split_byte;
   logic [31:0] merged_buffer;
   logic [2:0]  idx_next_wide;
   logic        more_bytes;
   logic [31:0] cur_va_next;
   logic [31:0] tbl_addr;
   logic [31:0] data_addr;

   // clamp the access length to 1..4
   assign len_clamp = (req.size_bytes == 3'd0) ? 3'd1 :
                      (req.size_bytes > 3'd4)  ? 3'd4 : req.size_bytes;
   assign req_end   = req.virt_addr + {29'd0, len_clamp} - 32'd1;

   // address and length of the access being translated
   assign cur_va  = state_ff.split_mode ? state_ff.saved_vaddr + {30'd0, state_ff.byte_index}
                                        : state_ff.saved_vaddr;
   assign cur_len = state_ff.split_mode ? 3'd1 : state_ff.saved_len;

   // byte lane handling for split accesses
   assign byte_shift    = {state_ff.byte_index, 3'b000};
   assign split_byte    = (state_ff.data_buffer >> byte_shift) & 32'h0000_00FF;
   assign merged_buffer = (state_ff.data_buffer & ~(32'h0000_00FF << byte_shift)) |
                          ({24'd0, req.mem_data[7:0]} << byte_shift);
   assign idx_next_wide = {1'b0, state_ff.byte_index} + 3'd1;
   assign more_bytes    = idx_next_wide < state_ff.saved_len;
   assign cur_va_next   = state_ff.saved_vaddr + {29'd0, idx_next_wide};

   // table entry and data addresses from the returned entry
   assign tbl_addr  = {req.mem_data[31:12], 12'd0} + {20'd0, cur_va[21:12], 2'b00};
   assign data_addr = {req.mem_data[31:12], cur_va[11:0]};

   // next state and result of one beat
   always_comb begin
      state_in  = state_ff;
      res       = '0;
      res_valid = 1'b0;
      if (req.command == CMD_REQUEST) begin
         if (state_ff.phase == PH_IDLE) begin
            res_valid            = 1'b1;
            state_in.saved_vaddr = req.virt_addr;
            state_in.saved_len   = len_clamp;
            state_in.byte_index  = 2'd0;
            state_in.store_flag  = req.is_store;
            state_in.data_buffer = req.is_store ? req.store_data : 32'd0;
            if (!paging_enable) begin
               state_in.split_mode = 1'b0;
               state_in.phase      = PH_DATA;
               res.action          = req.is_store ? ACT_WRITE : ACT_READ;
               res.phys_addr       = req.virt_addr;
               res.req_bytes       = len_clamp;
               res.out_data        = req.is_store ? (req.store_data & byte_mask(len_clamp))
                                                  : 32'd0;
            end else begin
               state_in.split_mode = (req.virt_addr[31:12] != req_end[31:12]);
               state_in.phase      = PH_DIR;
               res.action          = ACT_READ;
               res.phys_addr       = page_dir_base + {20'd0, req.virt_addr[31:22], 2'b00};
               res.req_bytes       = 3'd4;
            end
         end
      end else begin
         case (state_ff.phase)
            PH_DIR: begin
               res_valid = 1'b1;
               if (!req.mem_data[0]) begin
                  state_in.phase = PH_IDLE;
                  res.action     = ACT_FAULT;
                  res.phys_addr  = cur_va;
                  res.req_bytes  = cur_len;
               end else begin
                  state_in.phase = PH_TBL;
                  res.action     = ACT_READ;
                  res.phys_addr  = tbl_addr;
                  res.req_bytes  = 3'd4;
               end
            end
            PH_TBL: begin
               res_valid = 1'b1;
               if (!req.mem_data[0]) begin
                  state_in.phase = PH_IDLE;
                  res.action     = ACT_FAULT;
                  res.phys_addr  = cur_va;
                  res.req_bytes  = cur_len;
               end else begin
                  state_in.phase = PH_DATA;
                  res.action     = state_ff.store_flag ? ACT_WRITE : ACT_READ;
                  res.phys_addr  = data_addr;
                  res.req_bytes  = cur_len;
                  if (state_ff.store_flag) begin
                     res.out_data = state_ff.split_mode ? split_byte
                        : (state_ff.data_buffer & byte_mask(state_ff.saved_len));
                  end
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               if (!state_ff.split_mode) begin
                  state_in.phase = PH_IDLE;
                  res.action     = ACT_DONE;
                  res.phys_addr  = state_ff.saved_vaddr;
                  res.req_bytes  = state_ff.saved_len;
                  res.out_data   = state_ff.store_flag ? 32'd0
                                   : (req.mem_data & byte_mask(state_ff.saved_len));
               end else begin
                  if (!state_ff.store_flag) begin
                     state_in.data_buffer = merged_buffer;
                  end
                  if (more_bytes) begin
                     // next byte of a page-crossing access: walk again
                     state_in.byte_index = idx_next_wide[1:0];
                     state_in.phase      = PH_DIR;
                     res.action          = ACT_READ;
                     res.phys_addr       = page_dir_base + {20'd0, cur_va_next[31:22], 2'b00};
                     res.req_bytes       = 3'd4;
                  end else begin
                     state_in.phase = PH_IDLE;
                     res.action     = ACT_DONE;
                     res.phys_addr  = state_ff.saved_vaddr;
                     res.req_bytes  = state_ff.saved_len;
                     res.out_data   = state_ff.store_flag ? 32'd0 : merged_buffer;
                  end
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- src/tplw_out_reg.sv -----
module tplw_out_reg import tplw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       space,
   tplw_rsp_if.source rsp_chan
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // room for a new result when empty or the held beat leaves now
   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.action    = res_ff.action;
   assign rsp_chan.phys_addr = res_ff.phys_addr;
   assign rsp_chan.req_bytes = res_ff.req_bytes;
   assign rsp_chan.out_data  = res_ff.out_data;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import tplw_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 179;

   // predicted walk of one access unit and the results it owes
   class walk_scoreboard;
      bit          paging_on;
      bit [31:0]   dir_base;
      phase_type   phase;
      bit [31:0]   vaddr;
      bit [2:0]    len;
      bit [1:0]    idx;
      bit          split;
      bit          store;
      bit [31:0]   gather;
      bit [31:0]   dir_ent;
      result_type  due_results[$];
      int          errors;

      function new();
         paging_on = 1'b0;
         dir_base  = '0;
         phase     = PH_IDLE;
         vaddr     = '0;
         len       = '0;
         idx       = '0;
         split     = 1'b0;
         store     = 1'b0;
         gather    = '0;
         dir_ent   = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic sel, logic [31:0] value);
         if (sel == CSR_PAGING_ENABLE) paging_on = value[0];
         else dir_base = value;
      endfunction

      function bit [31:0] byte_window(bit [2:0] n);
         if (n >= 3'd4) return 32'hFFFF_FFFF;
         return (32'h1 << (8 * n)) - 32'h1;
      endfunction

      // address and length of the access being translated
      function bit [31:0] cur_va();
         return split ? vaddr + 32'(idx) : vaddr;
      endfunction

      function bit [2:0] cur_len();
         return split ? 3'd1 : len;
      endfunction

      function result_type make(bit [1:0] act, bit [31:0] addr, bit [2:0] n, bit [31:0] d);
         result_type r;
         r.action    = act;
         r.phys_addr = addr;
         r.req_bytes = n;
         r.out_data  = d;
         return r;
      endfunction

      function result_type dir_read();
         bit [31:0] va;
         va = cur_va();
         phase = PH_DIR;
         return make(ACT_READ, dir_base + {20'd0, va[31:22], 2'b00}, 3'd4, 32'd0);
      endfunction

      function result_type data_access(bit [31:0] addr);
         bit [31:0] d;
         d = '0;
         phase = PH_DATA;
         if (store) begin
            if (split) d = (gather >> (8 * idx)) & 32'hFF;
            else d = gather & byte_window(len);
         end
         return make(store ? ACT_WRITE : ACT_READ, addr, cur_len(), d);
      endfunction

      // one accepted beat; returns 1 when it causes a result
      function bit walk_step(req_type b, output result_type r);
         bit [2:0]  n;
         bit [31:0] last;
         bit [31:0] va;
         bit [31:0] mem;
         mem = b.mem_data;
         if (b.command == CMD_REQUEST) begin
            if (phase != PH_IDLE) return 1'b0;
            n = b.size_bytes;
            if (n == 3'd0) n = 3'd1;
            if (n > 3'd4) n = 3'd4;
            vaddr  = b.virt_addr;
            len    = n;
            idx    = '0;
            store  = b.is_store;
            gather = b.is_store ? b.store_data : 32'd0;
            if (!paging_on) begin
               split = 1'b0;
               r = data_access(vaddr);
               return 1'b1;
            end
            last  = vaddr + 32'(n) - 32'd1;
            split = (vaddr[31:12] != last[31:12]);
            r = dir_read();
            return 1'b1;
         end
         va = cur_va();
         case (phase)
            PH_DIR: begin
               if (!mem[0]) begin
                  phase = PH_IDLE;
                  r = make(ACT_FAULT, va, cur_len(), 32'd0);
                  return 1'b1;
               end
               dir_ent = mem;
               phase = PH_TBL;
               r = make(ACT_READ, {dir_ent[31:12], 12'd0} + {20'd0, va[21:12], 2'b00},
                        3'd4, 32'd0);
               return 1'b1;
            end
            PH_TBL: begin
               if (!mem[0]) begin
                  phase = PH_IDLE;
                  r = make(ACT_FAULT, va, cur_len(), 32'd0);
                  return 1'b1;
               end
               r = data_access({mem[31:12], va[11:0]});
               return 1'b1;
            end
            PH_DATA: begin
               if (!split) begin
                  phase = PH_IDLE;
                  r = make(ACT_DONE, vaddr, len, store ? 32'd0 : (mem & byte_window(len)));
                  return 1'b1;
               end
               // split read: drop the byte into its lane
               if (!store) gather[8 * idx +: 8] = mem[7:0];
               if (int'(idx) + 1 < int'(len)) begin
                  idx = idx + 2'd1;
                  r = dir_read();
                  return 1'b1;
               end
               phase = PH_IDLE;
               r = make(ACT_DONE, vaddr, len, store ? 32'd0 : gather);
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void note_beat(req_type b);
         result_type r;
         if (walk_step(b, r)) due_results.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            $error("unexpected result: action %0d phys_addr %h", got.action, got.phys_addr);
            errors++;
            return;
         end
         want = due_results.pop_front();
         if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            errors++;
         end
         if (got.phys_addr !== want.phys_addr) begin
            $error("phys_addr: expected %h, got %h", want.phys_addr, got.phys_addr);
            errors++;
         end
         if (got.req_bytes !== want.req_bytes) begin
            $error("req_bytes: expected %0d, got %0d", want.req_bytes, got.req_bytes);
            errors++;
         end
         if (got.out_data !== want.out_data) begin
            $error("out_data: expected %h, got %h", want.out_data, got.out_data);
            errors++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   send_mode = 0;
   int   take_mode = 0;
   int   beats_sent = 0;

   walk_scoreboard board = new();

   tplw_req_if req_if();
   tplw_rsp_if rsp_if();
   tplw_csr_if csr_if();

   two_level_page_walk_access dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("two_level_page_walk_access regression: fail");
         $finish;
      end
   end

   // observe every beat on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) board.write_reg(csr_if.index, csr_if.data);
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(result_type'{rsp_if.action, rsp_if.phys_addr,
                                            rsp_if.req_bytes, rsp_if.out_data});
         if (req_if.valid && req_if.ready)
            board.note_beat(req_type'{req_if.command, req_if.virt_addr, req_if.size_bytes,
                                      req_if.is_store, req_if.store_data, req_if.mem_data});
      end
   end

   function automatic int draw_wait(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 12);
         default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
      endcase
   endfunction

   // result side: random stalls per beat
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait(take_mode);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         @(negedge clock);
         taken++;
         if (taken % 40 == 0) take_mode = $urandom_range(0, 2);
      end
   end

   // one beat on the request channel, entered and left at a falling edge
   task automatic send_beat(input req_type b);
      int gap;
      gap = draw_wait(send_mode);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.command    <= b.command;
      req_if.virt_addr  <= b.virt_addr;
      req_if.size_bytes <= b.size_bytes;
      req_if.is_store   <= b.is_store;
      req_if.store_data <= b.store_data;
      req_if.mem_data   <= b.mem_data;
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
      beats_sent++;
      if (beats_sent % 40 == 0) send_mode = $urandom_range(0, 2);
   endtask

   task automatic ask(input logic [31:0] va, input logic [2:0] sz, input logic st,
                      input logic [31:0] sd);
      send_beat(req_type'{CMD_REQUEST, va, sz, st, sd, 32'($urandom)});
   endtask

   task automatic answer(input logic [31:0] mem);
      send_beat(req_type'{CMD_RESPONSE, 32'($urandom), 3'($urandom), 1'($urandom),
                          32'($urandom), mem});
   endtask

   // hold off until every owed result is back, then let the block settle
   task automatic settle(input int extra);
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [31:0] value);
      csr_if.index <= sel;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   // random access, biased towards page ends and the address extremes
   task automatic ask_random();
      logic [31:0] va;
      logic [31:0] t;
      logic [2:0]  sz;
      t = $urandom;
      case ($urandom_range(0, 15))
         0: va = 32'd0;
         1: va = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         2, 3, 4, 5: va = {t[31:12], 10'h3FF, t[1:0]};
         default: va = $urandom;
      endcase
      if ($urandom_range(0, 7) == 0) sz = 3'($urandom_range(0, 7));
      else sz = 3'($urandom_range(1, 4));
      ask(va, sz, 1'($urandom), 32'($urandom));
   endtask

   // memory reply: entries are mostly present
   function automatic logic [31:0] draw_mem();
      logic [31:0] m;
      m = $urandom;
      if (board.phase != PH_DATA) m[0] = ($urandom_range(0, 11) != 0);
      return m;
   endfunction

   initial begin
      logic        seg_paging [SEGMENTS];
      logic [31:0] seg_base [SEGMENTS];
      int          counted;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_REQUEST;
      req_if.virt_addr  <= '0;
      req_if.size_bytes <= 3'd1;
      req_if.is_store   <= 1'b0;
      req_if.store_data <= '0;
      req_if.mem_data   <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_PAGING_ENABLE;
      csr_if.data       <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // pass-through accesses, size clamping and a stray response
      csr_write(CSR_PAGING_ENABLE, 32'd0);
      csr_write(CSR_PAGE_DIR_BASE, 32'd0);
      ask(32'd0, 3'd4, 1'b0, 32'd0);
      answer(32'hFFFF_FFFF);
      ask(32'hFFFF_FFFF, 3'd0, 1'b1, 32'hFFFF_FFFF);
      answer(32'd0);
      answer(32'h1234_5677);

      // split read across the top of the address space, stray request while busy
      settle(3);
      csr_write(CSR_PAGING_ENABLE, 32'd1);
      csr_write(CSR_PAGE_DIR_BASE, 32'hFFFF_F000);
      ask(32'hFFFF_FFFF, 3'd2, 1'b0, 32'd0);
      ask(32'h0000_0040, 3'd4, 1'b1, 32'hCAFE_F00D);
      answer(32'hFFFF_FFFF);
      answer(32'h0000_0001);
      // directory base moved before the second byte's walk
      settle(3);
      csr_write(CSR_PAGE_DIR_BASE, 32'd0);
      answer(32'h0000_00A5);
      answer(32'h1234_5001);
      answer(32'hFFFF_F001);
      answer(32'h0000_005A);

      // clamped store, then faults at each level
      ask(32'h0000_1000, 3'd5, 1'b1, 32'h8765_4321);
      answer(32'h0000_0001);
      answer(32'h0000_0001);
      answer(32'hFFFF_FFFF);
      ask(32'd0, 3'd1, 1'b0, 32'd0);
      answer(32'hFFFF_FFFE);
      ask(32'hFFFF_FFFC, 3'd4, 1'b0, 32'd0);
      // paging switched off mid-walk must not affect this access
      settle(3);
      csr_write(CSR_PAGING_ENABLE, 32'd0);
      answer(32'hFFFF_FFFF);
      answer(32'hFFFF_FFFE);

      // random phases over several register settings
      seg_paging[0] = 1'b0; seg_base[0] = 32'd0;
      seg_paging[1] = 1'b1; seg_base[1] = 32'd0;
      seg_paging[2] = 1'b1; seg_base[2] = 32'hFFFF_FFFF;
      seg_paging[3] = 1'b1; seg_base[3] = $urandom;
      seg_paging[4] = 1'b0; seg_base[4] = 32'hFFFF_FFFF;
      seg_paging[5] = 1'b1; seg_base[5] = $urandom & 32'hFFFF_F000;
      for (int s = 0; s < SEGMENTS; s++) begin
         settle(3);
         csr_write(CSR_PAGING_ENABLE, {31'd0, seg_paging[s]});
         csr_write(CSR_PAGE_DIR_BASE, seg_base[s]);
         counted = 0;
         while (counted < SEG_ITEMS) begin
            if (board.phase == PH_IDLE) begin
               if ($urandom_range(0, 19) == 0) answer($urandom);
               else begin
                  ask_random();
                  counted++;
               end
            end else begin
               if ($urandom_range(0, 19) == 0) ask_random();
               else begin
                  answer(draw_mem());
                  counted++;
               end
            end
            if ($urandom_range(0, 59) == 0) settle(0);
         end
      end

      settle(0);
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("two_level_page_walk_access regression: pass");
      else
         $display("two_level_page_walk_access regression: fail");
      $finish;
   end

endmodule
